// ===== design/cpi_pkg.sv =====
// Circle pair intersection: shared constants and the result status codes.
// No dependencies.
package cpi_pkg;

   localparam int COORD_BITS_DEF = 24;
   localparam int FRAC_BITS_DEF  = 8;

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_SHORT  = 2'd1,
      STATUS_NOMEET = 2'd2
   } status_type;

endpackage

// ===== design/cpi_mul.sv =====
// Two-stage unsigned multiplier built from four half-width partial products.
// No dependencies.
module cpi_mul #(
   parameter int WA = 26,
   parameter int WB = 26
) (
   input  logic               clock,
   input  logic [WA-1:0]      a_i,
   input  logic [WB-1:0]      b_i,
   output logic [WA+WB-1:0]   p_o
);
   localparam int LA = (WA + 1) / 2;
   localparam int HA = WA - LA;
   localparam int LB = (WB + 1) / 2;
   localparam int HB = WB - LB;
   localparam int PW = WA + WB;

   logic [LA+LB-1:0] pp_ll_ff, pp_ll_in;
   logic [LA+HB-1:0] pp_lh_ff, pp_lh_in;
   logic [HA+LB-1:0] pp_hl_ff, pp_hl_in;
   logic [HA+HB-1:0] pp_hh_ff, pp_hh_in;
   logic [PW-1:0]    p_ff, p_in;

   always_comb begin
      pp_ll_in = (LA+LB)'(a_i[LA-1:0]) * (LA+LB)'(b_i[LB-1:0]);
      pp_lh_in = (LA+HB)'(a_i[LA-1:0]) * (LA+HB)'(b_i[WB-1:LB]);
      pp_hl_in = (HA+LB)'(a_i[WA-1:LA]) * (HA+LB)'(b_i[LB-1:0]);
      pp_hh_in = (HA+HB)'(a_i[WA-1:LA]) * (HA+HB)'(b_i[WB-1:LB]);
      p_in = (PW'(pp_hh_ff) << (LA + LB)) + (PW'(pp_hl_ff) << LA)
           + (PW'(pp_lh_ff) << LB) + PW'(pp_ll_ff);
   end

   always_ff @(posedge clock) begin
      pp_ll_ff <= pp_ll_in;
      pp_lh_ff <= pp_lh_in;
      pp_hl_ff <= pp_hl_in;
      pp_hh_ff <= pp_hh_in;
      p_ff     <= p_in;
   end

   assign p_o = p_ff;

endmodule

// ===== design/cpi_sqrt.sv =====
// Pipelined restoring integer square root, one result bit per stage.
// No dependencies.
module cpi_sqrt #(
   parameter int XW = 98
) (
   input  logic              clock,
   input  logic [XW-1:0]     x_i,
   output logic [XW/2-1:0]   root_o
);
   localparam int RW  = XW / 2;
   localparam int RMW = RW + 1;
   localparam int TW  = RW + 3;

   logic [XW-1:0]  x_ff    [1:RW];
   logic [XW-1:0]  x_in    [1:RW];
   logic [RMW-1:0] rem_ff  [1:RW];
   logic [RMW-1:0] rem_in  [1:RW];
   logic [RW-1:0]  root_ff [1:RW];
   logic [RW-1:0]  root_in [1:RW];

   always_comb begin
      logic [XW-1:0]  cx;
      logic [RMW-1:0] crem;
      logic [RW-1:0]  croot;
      logic [TW-1:0]  remsh;
      logic [TW-1:0]  trial;
      logic           ge;
      for (int j = 1; j <= RW; j++) begin
         if (j == 1) begin
            cx    = x_i;
            crem  = '0;
            croot = '0;
         end else begin
            cx    = x_ff[j-1];
            crem  = rem_ff[j-1];
            croot = root_ff[j-1];
         end
         remsh      = (TW'(crem) << 2) | TW'(cx[XW-1:XW-2]);
         trial      = (TW'(croot) << 2) | TW'(1);
         ge         = remsh >= trial;
         rem_in[j]  = ge ? RMW'(remsh - trial) : RMW'(remsh);
         root_in[j] = RW'({croot, ge});
         x_in[j]    = cx << 2;
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 1; j <= RW; j++) begin
         x_ff[j]    <= x_in[j];
         rem_ff[j]  <= rem_in[j];
         root_ff[j] <= root_in[j];
      end
   end

   assign root_o = root_ff[RW];

endmodule

// ===== design/cpi_div.sv =====
// Pipelined floor division of a signed numerator by a positive divisor, added
// to a base coordinate and saturated. One quotient bit per stage. No dependencies.
module cpi_div #(
   parameter int COORD_BITS = 24,
   parameter int NW         = 77,
   parameter int DENW       = 51
) (
   input  logic                         clock,
   input  logic signed [NW-1:0]         num_i,
   input  logic [DENW-1:0]              den_i,
   input  logic signed [COORD_BITS-1:0] base_i,
   output logic signed [COORD_BITS-1:0] coord_o
);
   localparam int C  = COORD_BITS;
   localparam int MW = NW;
   localparam int QW = C + 1;
   localparam int XW = MW + QW;
   localparam int SW = C + 3;
   localparam logic signed [C-1:0] CMAX = {1'b0, {(C-1){1'b1}}};
   localparam logic signed [C-1:0] CMIN = {1'b1, {(C-1){1'b0}}};

   logic [MW-1:0]         m1_ff, m1_in;
   logic                  neg1_ff;
   logic [DENW-1:0]       den1_ff;
   logic signed [C-1:0]   base1_ff;

   logic [MW-1:0]         rem_ff  [0:QW];
   logic [MW-1:0]         rem_in  [1:QW];
   logic [QW-1:0]         q_ff    [0:QW];
   logic [QW-1:0]         q_in    [1:QW];
   logic [DENW-1:0]       den_ff  [0:QW];
   logic signed [C-1:0]   base_ff [0:QW];
   logic                  neg_ff  [0:QW];
   logic                  big_ff  [0:QW];
   logic                  big0_in;

   logic signed [SW-1:0]  sum_ff, sum_in;
   logic                  negs_ff, bigs_ff;
   logic signed [C-1:0]   out_ff, out_in;

   always_comb begin
      logic [XW-1:0]        sh;
      logic                 ge;
      logic signed [SW-1:0] qext;
      logic signed [SW-1:0] bext;
      m1_in = num_i[NW-1] ? (MW'(den_i) - MW'(1) - MW'(num_i)) : MW'(num_i);
      big0_in = XW'(m1_ff) >= (XW'(den1_ff) << QW);
      for (int j = 0; j < QW; j++) begin
         sh          = XW'(den_ff[j]) << (QW - 1 - j);
         ge          = XW'(rem_ff[j]) >= sh;
         rem_in[j+1] = ge ? MW'(XW'(rem_ff[j]) - sh) : rem_ff[j];
         q_in[j+1]   = q_ff[j];
         q_in[j+1][QW-1-j] = ge;
      end
      qext   = $signed(SW'(q_ff[QW]));
      bext   = SW'(base_ff[QW]);
      sum_in = neg_ff[QW] ? bext - qext : bext + qext;
      if (bigs_ff) begin
         out_in = negs_ff ? CMIN : CMAX;
      end else if (sum_ff > SW'(CMAX)) begin
         out_in = CMAX;
      end else if (sum_ff < SW'(CMIN)) begin
         out_in = CMIN;
      end else begin
         out_in = C'(sum_ff);
      end
   end

   always_ff @(posedge clock) begin
      m1_ff      <= m1_in;
      neg1_ff    <= num_i[NW-1];
      den1_ff    <= den_i;
      base1_ff   <= base_i;
      rem_ff[0]  <= m1_ff;
      q_ff[0]    <= '0;
      den_ff[0]  <= den1_ff;
      base_ff[0] <= base1_ff;
      neg_ff[0]  <= neg1_ff;
      big_ff[0]  <= big0_in;
      for (int j = 1; j <= QW; j++) begin
         rem_ff[j]  <= rem_in[j];
         q_ff[j]    <= q_in[j];
         den_ff[j]  <= den_ff[j-1];
         base_ff[j] <= base_ff[j-1];
         neg_ff[j]  <= neg_ff[j-1];
         big_ff[j]  <= big_ff[j-1];
      end
      sum_ff  <= sum_in;
      negs_ff <= neg_ff[QW];
      bigs_ff <= big_ff[QW];
      out_ff  <= out_in;
   end

   assign coord_o = out_ff;

endmodule

// ===== design/circle_pair_intersection_top.sv =====
// Circle pair intersection. Takes one request per cycle with no gaps; busy is
// high only during reset. Most of its depth lies in the square-root pipeline
// (2*COORD_BITS + 1 stages) and the saturating dividers (COORD_BITS + 5 stages).
// The receiver cannot stall: each result shows for one cycle on rsp_strobe.
// Write csr_wdata only while idle.
// Depends on cpi_pkg, cpi_mul, cpi_sqrt and cpi_div.
module circle_pair_intersection_top #(
   parameter int COORD_BITS = cpi_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = cpi_pkg::FRAC_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic signed [COORD_BITS-1:0] req_first_x,
   input  logic signed [COORD_BITS-1:0] req_first_y,
   input  logic [COORD_BITS-2:0]        req_first_radius,
   input  logic signed [COORD_BITS-1:0] req_second_x,
   input  logic signed [COORD_BITS-1:0] req_second_y,
   input  logic [COORD_BITS-2:0]        req_second_radius,
   input  logic                         csr_we,
   input  logic [COORD_BITS-2:0]        csr_wdata,
   output logic                         rsp_strobe,
   output cpi_pkg::status_type          rsp_status,
   output logic signed [COORD_BITS-1:0] rsp_point_a_x,
   output logic signed [COORD_BITS-1:0] rsp_point_a_y,
   output logic signed [COORD_BITS-1:0] rsp_point_b_x,
   output logic signed [COORD_BITS-1:0] rsp_point_b_y
);
   import cpi_pkg::*;

   localparam int C    = COORD_BITS;
   localparam int DXW  = C + 1;
   localparam int RADW = C - 1;
   localparam int SQW  = 2 * DXW;
   localparam int RSQW = 2 * RADW;
   localparam int DW   = 2 * C + 2;
   localparam int AW   = DW + 1;
   localparam int AMW  = DW;
   localparam int A2W  = 2 * AMW;
   localparam int DRW  = DW + RSQW;
   localparam int HW   = DRW + 2;
   localparam int RTW  = HW / 2;
   localparam int PAW  = AMW + DXW;
   localparam int PHW  = RTW + DXW;
   localparam int NW   = 3 * C + 5;
   localparam int DENW = DW + 1;

   localparam int S_AM   = 7;
   localparam int S_HQ   = 9;
   localparam int S_H    = 10;
   localparam int S_RT   = S_H + RTW;
   localparam int S_PR   = S_RT + 2;
   localparam int S_NUM  = S_PR + 1;
   localparam int S_OUT0 = S_NUM + C + 5;
   localparam int S_OUT  = S_OUT0 + 1;

   localparam logic [RADW-1:0] MB_RESET = RADW'(64'd2 << FRAC_BITS);

   typedef struct packed {
      logic signed [C-1:0] x1;
      logic signed [C-1:0] y1;
      logic [DXW-1:0]      dxm;
      logic                dxs;
      logic [DXW-1:0]      dym;
      logic                dys;
   } geo_type;

   typedef struct packed {
      logic [DW-1:0]  d;
      logic [AMW-1:0] am;
      logic           as;
      logic           sh;
      logic           zr;
   } quad_type;

   logic [RADW-1:0]       csr_min_baseline_ff;
   logic                  v_ff [1:S_OUT];

   logic signed [DXW-1:0] dx1_ff, dx1_in, dy1_ff, dy1_in;
   logic [RADW-1:0]       r1_1_ff, r2_1_ff, r1_2_ff, r2_2_ff;
   logic signed [C-1:0]   x1_1_ff, y1_1_ff;
   geo_type               geo_ff [2:S_PR];
   geo_type               geo_in;

   logic [SQW-1:0]        dxsq, dysq;
   logic [RSQW-1:0]       r1sq, r2sq, mbsq;

   logic [DW-1:0]         d5_ff, d5_in, d6_ff;
   logic signed [RSQW:0]  rd5_ff, rd5_in;
   logic [RSQW-1:0]       mbsq5_ff, r1sq5_ff, r1sq6_ff, r1sq7_ff;
   logic signed [AW-1:0]  a6_ff, a6_in;
   logic                  sh6_ff, zr6_ff;
   quad_type              qd_ff [S_AM:S_PR];
   quad_type              qd_in;

   logic [A2W-1:0]        am2;
   logic [DRW-1:0]        dr;
   logic [HW-1:0]         four;
   logic                  hneg;
   logic [HW-1:0]         h10_ff, h10_in;
   status_type            st_ff [S_H:S_OUT0];
   status_type            st10_in;

   logic [RTW-1:0]        root;
   logic [PAW-1:0]        pax, pay;
   logic [PHW-1:0]        phx, phy;

   logic signed [NW-1:0]  nax_ff, nay_ff, nbx_ff, nby_ff;
   logic signed [NW-1:0]  nax_in, nay_in, nbx_in, nby_in;
   logic [DENW-1:0]       den_ff, den_in;
   logic signed [C-1:0]   bx_ff, by_ff;
   logic signed [C-1:0]   cax, cay, cbx, cby;

   status_type            out_st_ff;
   logic signed [C-1:0]   out_ax_ff, out_ay_ff, out_bx_ff, out_by_ff;

   // front end: differences and magnitudes
   always_comb begin
      dx1_in = $signed({req_second_x[C-1], req_second_x})
             - $signed({req_first_x[C-1], req_first_x});
      dy1_in = $signed({req_second_y[C-1], req_second_y})
             - $signed({req_first_y[C-1], req_first_y});
      geo_in.x1  = x1_1_ff;
      geo_in.y1  = y1_1_ff;
      geo_in.dxs = dx1_ff[DXW-1];
      geo_in.dxm = dx1_ff[DXW-1] ? DXW'(-dx1_ff) : DXW'(dx1_ff);
      geo_in.dys = dy1_ff[DXW-1];
      geo_in.dym = dy1_ff[DXW-1] ? DXW'(-dy1_ff) : DXW'(dy1_ff);
   end

   cpi_mul #(.WA(DXW), .WB(DXW)) u_mul_dx (
      .clock(clock), .a_i(geo_ff[2].dxm), .b_i(geo_ff[2].dxm), .p_o(dxsq));
   cpi_mul #(.WA(DXW), .WB(DXW)) u_mul_dy (
      .clock(clock), .a_i(geo_ff[2].dym), .b_i(geo_ff[2].dym), .p_o(dysq));
   cpi_mul #(.WA(RADW), .WB(RADW)) u_mul_r1 (
      .clock(clock), .a_i(r1_2_ff), .b_i(r1_2_ff), .p_o(r1sq));
   cpi_mul #(.WA(RADW), .WB(RADW)) u_mul_r2 (
      .clock(clock), .a_i(r2_2_ff), .b_i(r2_2_ff), .p_o(r2sq));
   cpi_mul #(.WA(RADW), .WB(RADW)) u_mul_mb (
      .clock(clock), .a_i(csr_min_baseline_ff), .b_i(csr_min_baseline_ff),
      .p_o(mbsq));

   // distance, power term and flags
   always_comb begin
      d5_in  = DW'(dxsq) + DW'(dysq);
      rd5_in = $signed({1'b0, r1sq}) - $signed({1'b0, r2sq});
      a6_in  = $signed({1'b0, d5_ff}) + AW'(rd5_ff);
      qd_in.d  = d6_ff;
      qd_in.as = a6_ff[AW-1];
      qd_in.am = a6_ff[AW-1] ? AMW'(-a6_ff) : AMW'(a6_ff);
      qd_in.sh = sh6_ff;
      qd_in.zr = zr6_ff;
   end

   cpi_mul #(.WA(AMW), .WB(AMW)) u_mul_a2 (
      .clock(clock), .a_i(qd_ff[S_AM].am), .b_i(qd_ff[S_AM].am), .p_o(am2));
   cpi_mul #(.WA(DW), .WB(RSQW)) u_mul_dr (
      .clock(clock), .a_i(qd_ff[S_AM].d), .b_i(r1sq7_ff), .p_o(dr));

   always_comb begin
      four   = {dr, 2'b00};
      hneg   = am2 > A2W'(four);
      h10_in = HW'(A2W'(four) - am2);
      if (qd_ff[S_HQ].sh) begin
         st10_in = STATUS_SHORT;
      end else if (qd_ff[S_HQ].zr || hneg) begin
         st10_in = STATUS_NOMEET;
      end else begin
         st10_in = STATUS_OK;
      end
   end

   cpi_sqrt #(.XW(HW)) u_sqrt (.clock(clock), .x_i(h10_ff), .root_o(root));

   cpi_mul #(.WA(AMW), .WB(DXW)) u_mul_ax (
      .clock(clock), .a_i(qd_ff[S_RT].am), .b_i(geo_ff[S_RT].dxm), .p_o(pax));
   cpi_mul #(.WA(AMW), .WB(DXW)) u_mul_ay (
      .clock(clock), .a_i(qd_ff[S_RT].am), .b_i(geo_ff[S_RT].dym), .p_o(pay));
   cpi_mul #(.WA(RTW), .WB(DXW)) u_mul_hx (
      .clock(clock), .a_i(root), .b_i(geo_ff[S_RT].dxm), .p_o(phx));
   cpi_mul #(.WA(RTW), .WB(DXW)) u_mul_hy (
      .clock(clock), .a_i(root), .b_i(geo_ff[S_RT].dym), .p_o(phy));

   // signed numerators, with the rounding offset folded in
   always_comb begin
      logic signed [NW-1:0] sax, say, shx, shy, sd;
      sax = $signed(NW'(pax));
      say = $signed(NW'(pay));
      shx = $signed(NW'(phx));
      shy = $signed(NW'(phy));
      sd  = $signed(NW'(qd_ff[S_PR].d));
      if (qd_ff[S_PR].as ^ geo_ff[S_PR].dxs) sax = -sax;
      if (qd_ff[S_PR].as ^ geo_ff[S_PR].dys) say = -say;
      if (geo_ff[S_PR].dxs) shx = -shx;
      if (geo_ff[S_PR].dys) shy = -shy;
      nax_in = sax + shy + sd;
      nay_in = say - shx + sd;
      nbx_in = sax - shy + sd;
      nby_in = say + shx + sd;
      den_in = {qd_ff[S_PR].d, 1'b0};
   end

   cpi_div #(.COORD_BITS(C), .NW(NW), .DENW(DENW)) u_div_ax (
      .clock(clock), .num_i(nax_ff), .den_i(den_ff), .base_i(bx_ff), .coord_o(cax));
   cpi_div #(.COORD_BITS(C), .NW(NW), .DENW(DENW)) u_div_ay (
      .clock(clock), .num_i(nay_ff), .den_i(den_ff), .base_i(by_ff), .coord_o(cay));
   cpi_div #(.COORD_BITS(C), .NW(NW), .DENW(DENW)) u_div_bx (
      .clock(clock), .num_i(nbx_ff), .den_i(den_ff), .base_i(bx_ff), .coord_o(cbx));
   cpi_div #(.COORD_BITS(C), .NW(NW), .DENW(DENW)) u_div_by (
      .clock(clock), .num_i(nby_ff), .den_i(den_ff), .base_i(by_ff), .coord_o(cby));

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_min_baseline_ff <= MB_RESET;
         for (int k = 1; k <= S_OUT; k++) begin
            v_ff[k] <= 1'b0;
         end
      end else begin
         if (csr_we) begin
            csr_min_baseline_ff <= csr_wdata;
         end
         v_ff[1] <= start && !busy;
         for (int k = 2; k <= S_OUT; k++) begin
            v_ff[k] <= v_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      dx1_ff    <= dx1_in;
      dy1_ff    <= dy1_in;
      r1_1_ff   <= req_first_radius;
      r2_1_ff   <= req_second_radius;
      x1_1_ff   <= req_first_x;
      y1_1_ff   <= req_first_y;
      r1_2_ff   <= r1_1_ff;
      r2_2_ff   <= r2_1_ff;
      geo_ff[2] <= geo_in;
      for (int k = 3; k <= S_PR; k++) begin
         geo_ff[k] <= geo_ff[k-1];
      end
      d5_ff    <= d5_in;
      rd5_ff   <= rd5_in;
      mbsq5_ff <= mbsq;
      r1sq5_ff <= r1sq;
      a6_ff    <= a6_in;
      d6_ff    <= d5_ff;
      sh6_ff   <= d5_ff < DW'(mbsq5_ff);
      zr6_ff   <= d5_ff == '0;
      r1sq6_ff <= r1sq5_ff;
      r1sq7_ff <= r1sq6_ff;
      qd_ff[S_AM] <= qd_in;
      for (int k = S_AM + 1; k <= S_PR; k++) begin
         qd_ff[k] <= qd_ff[k-1];
      end
      h10_ff     <= h10_in;
      st_ff[S_H] <= st10_in;
      for (int k = S_H + 1; k <= S_OUT0; k++) begin
         st_ff[k] <= st_ff[k-1];
      end
      nax_ff <= nax_in;
      nay_ff <= nay_in;
      nbx_ff <= nbx_in;
      nby_ff <= nby_in;
      den_ff <= den_in;
      bx_ff  <= geo_ff[S_PR].x1;
      by_ff  <= geo_ff[S_PR].y1;
      out_st_ff <= st_ff[S_OUT0];
      out_ax_ff <= (st_ff[S_OUT0] == STATUS_OK) ? cax : '0;
      out_ay_ff <= (st_ff[S_OUT0] == STATUS_OK) ? cay : '0;
      out_bx_ff <= (st_ff[S_OUT0] == STATUS_OK) ? cbx : '0;
      out_by_ff <= (st_ff[S_OUT0] == STATUS_OK) ? cby : '0;
   end

   assign busy          = reset;
   assign rsp_strobe    = v_ff[S_OUT];
   assign rsp_status    = out_st_ff;
   assign rsp_point_a_x = out_ax_ff;
   assign rsp_point_a_y = out_ay_ff;
   assign rsp_point_b_x = out_bx_ff;
   assign rsp_point_b_y = out_by_ff;

   a_reject_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status != STATUS_OK |->
         rsp_point_a_x == '0 && rsp_point_a_y == '0 &&
         rsp_point_b_x == '0 && rsp_point_b_y == '0)
      else $error("rejected request carries non-zero points");

   a_fixed_latency : assert property (@(posedge clock) disable iff (reset)
      v_ff[S_H] |-> ##(S_OUT - S_H) rsp_strobe)
      else $error("request lost between square root and output");

   a_status_kept : assert property (@(posedge clock) disable iff (reset)
      v_ff[S_H] && st_ff[S_H] == STATUS_OK |-> ##(S_OUT - S_H)
         rsp_status == STATUS_OK)
      else $error("status misaligned with its request");

endmodule
